// File: sv/bxavg_pkg.sv
`default_nettype none

package bxavg_pkg;

   // widths fixed by the register map and the pixel format
   localparam int CfgW    = 12;
   localparam int ChanW   = 8;
   localparam int NumChan = 3;
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;

   // register index, taken from paddr bit 2
   localparam logic REG_SOURCE_WIDTH  = 1'b0;
   localparam logic REG_SOURCE_HEIGHT = 1'b1;

   // one rgb pixel, red in the lowest bits
   typedef struct packed {
      logic [ChanW-1:0] blue;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] red;
   } pixel_type;

   // row and frame markers carried with a result
   typedef struct packed {
      logic row_last;
      logic frame_last;
   } marks_type;

endpackage

`default_nettype wire

// File: sv/bxavg_ram.sv
`default_nettype none

module bxavg_ram #(
   parameter int Width = 36,
   parameter int Depth = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // read returns the contents from before a same-cycle write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/box_average_downscale_by_four_core.sv
`default_nettype none

// Area-average downscaler. RGB source pixels enter in raster order on req_ and every complete
// SCALE x SCALE block gives one pixel on rsp_ whose channels are the block sums divided by
// SCALE*SCALE, truncated; rsp_tlast marks the last pixel of an output row and rsp_tuser the last
// pixel of the frame. Columns and rows past the last whole block are taken and dropped. One
// pixel is taken every clock: partial block sums live in a line memory of
// MAX_SOURCE_WIDTH/SCALE entries that is read when a pixel is taken and written back as the pixel
// leaves stage 1, with the last written entry forwarded so that neighboring pixels of one block follow
// each other without a gap. The sums of a finished block are registered in stage 2 and then in the
// output register. Throughput drops only while rsp_tready is low. The line memory needs no clearing
// after reset. source_width (byte address 0) and source_height (byte address 4) are written over
// the csr_ port between frames; a width above MAX_SOURCE_WIDTH counts as MAX_SOURCE_WIDTH.

module box_average_downscale_by_four_core #(
   parameter int SCALE            = 4,
   parameter int MAX_SOURCE_WIDTH = 2048
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // source pixels
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [23:0]                        req_tdata,   // red_in, green_in, blue_in
   // averaged pixels
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [23:0]                             rsp_tdata,   // red_out, green_out, blue_out
   output logic                                    rsp_tlast,   // row_end
   output logic                                    rsp_tuser,   // frame_end
   // register port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [bxavg_pkg::CsrAddrW-1:0]     csr_paddr,
   input  wire logic [bxavg_pkg::CsrDataW-1:0]     csr_pwdata,
   output logic      [bxavg_pkg::CsrDataW-1:0]     csr_prdata,
   output logic                                    csr_pready
);

   localparam int NumBlocks = MAX_SOURCE_WIDTH / SCALE;
   localparam int AddrW     = $clog2(NumBlocks);
   localparam int BlkW      = $clog2(NumBlocks + 1);
   localparam int ColW      = $clog2(MAX_SOURCE_WIDTH);
   localparam int CntW      = ColW + 1;
   localparam int SpanW     = ColW + 2;
   localparam int RowSpanW  = bxavg_pkg::CfgW + 1;
   localparam int PhW       = $clog2(SCALE);
   localparam int Area      = SCALE * SCALE;
   localparam int SumW      = $clog2(Area * 255 + 1);
   localparam int WordW     = bxavg_pkg::NumChan * SumW;
   localparam int ShiftW    = SumW + $clog2(Area);
   localparam int RecW      = SumW + 2;
   localparam int ProdW     = SumW + RecW;
   localparam logic [RecW-1:0] Recip =
      RecW'(((64'd1 << ShiftW) + 64'(Area) - 64'd1) / 64'(Area));

   // ---------------------------------------------------------------- registers
   logic [bxavg_pkg::CfgW-1:0] src_width_ff, src_width_in;
   logic [bxavg_pkg::CfgW-1:0] src_height_ff, src_height_in;
   logic                       csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // register decode
   always_comb begin
      src_width_in  = src_width_ff;
      src_height_in = src_height_ff;
      csr_prdata    = '0;
      unique case (csr_paddr[2])
         bxavg_pkg::REG_SOURCE_WIDTH: begin
            csr_prdata = bxavg_pkg::CsrDataW'(src_width_ff);
            if (csr_write) begin
               src_width_in = csr_pwdata[bxavg_pkg::CfgW-1:0];
            end
         end
         bxavg_pkg::REG_SOURCE_HEIGHT: begin
            csr_prdata = bxavg_pkg::CsrDataW'(src_height_ff);
            if (csr_write) begin
               src_height_in = csr_pwdata[bxavg_pkg::CfgW-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= bxavg_pkg::CfgW'(640);
         src_height_ff <= bxavg_pkg::CfgW'(480);
      end else begin
         src_width_ff  <= src_width_in;
         src_height_ff <= src_height_in;
      end
   end

   // width clipped to the line memory
   logic [CntW-1:0] width_sat;

   always_comb begin
      if (32'(src_width_ff) > 32'(MAX_SOURCE_WIDTH)) begin
         width_sat = CntW'(MAX_SOURCE_WIDTH);
      end else begin
         width_sat = CntW'(src_width_ff);
      end
   end

   // ---------------------------------------------------------------- position counters
   logic [ColW-1:0]                col_ff, col_in;
   logic [PhW-1:0]                 col_phase_ff, col_phase_in;
   logic [BlkW-1:0]                blk_ff, blk_in;
   logic [ColW-1:0]                blk_start_ff, blk_start_in;
   logic [bxavg_pkg::CfgW-1:0]     row_ff, row_in;
   logic [PhW-1:0]                 row_phase_ff, row_phase_in;
   logic [bxavg_pkg::CfgW-1:0]     brow_start_ff, brow_start_in;
   logic                           req_accept;
   logic                           col_wrap;
   logic                           row_wrap;

   assign req_accept = req_tvalid & req_tready;
   assign col_wrap   = (CntW'(col_ff) + CntW'(1)) >= width_sat;
   assign row_wrap   = (RowSpanW'(row_ff) + RowSpanW'(1)) >= RowSpanW'(src_height_ff);

   // advance column, block and row on each taken pixel
   always_comb begin
      col_in        = col_ff;
      col_phase_in  = col_phase_ff;
      blk_in        = blk_ff;
      blk_start_in  = blk_start_ff;
      row_in        = row_ff;
      row_phase_in  = row_phase_ff;
      brow_start_in = brow_start_ff;
      if (req_accept) begin
         if (col_wrap) begin
            col_in       = '0;
            col_phase_in = '0;
            blk_in       = '0;
            blk_start_in = '0;
            if (row_wrap) begin
               row_in        = '0;
               row_phase_in  = '0;
               brow_start_in = '0;
            end else begin
               row_in = row_ff + bxavg_pkg::CfgW'(1);
               if (row_phase_ff == PhW'(SCALE - 1)) begin
                  row_phase_in  = '0;
                  brow_start_in = brow_start_ff + bxavg_pkg::CfgW'(SCALE);
               end else begin
                  row_phase_in = row_phase_ff + PhW'(1);
               end
            end
         end else begin
            col_in = col_ff + ColW'(1);
            if (col_phase_ff == PhW'(SCALE - 1)) begin
               col_phase_in = '0;
               blk_in       = blk_ff + BlkW'(1);
               blk_start_in = blk_start_ff + ColW'(SCALE);
            end else begin
               col_phase_in = col_phase_ff + PhW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         col_phase_ff  <= '0;
         blk_ff        <= '0;
         blk_start_ff  <= '0;
         row_ff        <= '0;
         row_phase_ff  <= '0;
         brow_start_ff <= '0;
      end else begin
         col_ff        <= col_in;
         col_phase_ff  <= col_phase_in;
         blk_ff        <= blk_in;
         blk_start_ff  <= blk_start_in;
         row_ff        <= row_in;
         row_phase_ff  <= row_phase_in;
         brow_start_ff <= brow_start_in;
      end
   end

   // block classification of the pixel at the counters
   logic                 in_block;
   logic                 blk_first;
   logic                 blk_done;
   bxavg_pkg::marks_type marks;

   always_comb begin
      in_block = ((SpanW'(blk_start_ff) + SpanW'(SCALE)) <= SpanW'(width_sat)) &&
                 ((RowSpanW'(brow_start_ff) + RowSpanW'(SCALE)) <= RowSpanW'(src_height_ff));
      blk_first = (row_phase_ff == '0) && (col_phase_ff == '0);
      blk_done  = (row_phase_ff == PhW'(SCALE - 1)) && (col_phase_ff == PhW'(SCALE - 1));
      marks.row_last   = (SpanW'(blk_start_ff) + SpanW'(2 * SCALE)) > SpanW'(width_sat);
      marks.frame_last = marks.row_last &&
         ((RowSpanW'(brow_start_ff) + RowSpanW'(2 * SCALE)) > RowSpanW'(src_height_ff));
   end

   // ---------------------------------------------------------------- stage 1: read-modify-write
   logic                 s1_valid_ff, s1_valid_in;
   bxavg_pkg::pixel_type s1_pix_ff;
   logic [AddrW-1:0]     s1_addr_ff;
   logic                 s1_write_ff;
   logic                 s1_first_ff;
   logic                 s1_produce_ff;
   bxavg_pkg::marks_type s1_marks_ff;
   logic                 s1_adv;

   logic                 s2_valid_ff, s2_valid_in;
   logic [WordW-1:0]     s2_sum_ff;
   bxavg_pkg::marks_type s2_marks_ff;
   logic                 s2_adv;
   logic                 s2_free;

   logic                 rsp_valid_ff, rsp_valid_in;
   bxavg_pkg::pixel_type rsp_pix_ff;
   bxavg_pkg::marks_type rsp_marks_ff;
   logic                 out_free;

   logic [WordW-1:0]     ram_rd_data;
   logic                 ram_wr_en;
   logic [WordW-1:0]     new_sum;
   logic [WordW-1:0]     old_sum;

   logic [AddrW-1:0]     last_addr_ff;
   logic [WordW-1:0]     last_sum_ff;
   logic                 last_valid_ff;

   // handshake chain from the output back to the input
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign s2_adv      = s2_valid_ff && out_free;
   assign s2_free     = !s2_valid_ff || out_free;
   assign s1_adv      = s1_valid_ff && (!s1_produce_ff || s2_free);
   assign req_tready  = !s1_valid_ff || s1_adv;
   assign s1_valid_in = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pix_ff     <= bxavg_pkg::pixel_type'(req_tdata);
         s1_addr_ff    <= blk_ff[AddrW-1:0];
         s1_write_ff   <= in_block;
         s1_first_ff   <= blk_first;
         s1_produce_ff <= in_block && blk_done;
         s1_marks_ff   <= marks;
      end
   end

   bxavg_ram #(
      .Width (WordW),
      .Depth (NumBlocks)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (new_sum),
      .rd_en   (req_accept),
      .rd_addr (blk_ff[AddrW-1:0]),
      .rd_data (ram_rd_data)
   );

   // latest write to the same entry overrides the memory read
   assign old_sum   = (last_valid_ff && (last_addr_ff == s1_addr_ff)) ? last_sum_ff : ram_rd_data;
   assign ram_wr_en = s1_adv && s1_write_ff;

   // first pixel of a block overwrites, the rest accumulate
   always_comb begin
      new_sum = '0;
      for (int k = 0; k < bxavg_pkg::NumChan; k++) begin
         if (s1_first_ff) begin
            new_sum[k*SumW +: SumW] = SumW'(s1_pix_ff[k*bxavg_pkg::ChanW +: bxavg_pkg::ChanW]);
         end else begin
            new_sum[k*SumW +: SumW] = old_sum[k*SumW +: SumW] +
               SumW'(s1_pix_ff[k*bxavg_pkg::ChanW +: bxavg_pkg::ChanW]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_valid_ff <= 1'b0;
      end else if (ram_wr_en) begin
         last_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_wr_en) begin
         last_addr_ff <= s1_addr_ff;
         last_sum_ff  <= new_sum;
      end
   end

   // ---------------------------------------------------------------- stage 2: divide by area
   assign s2_valid_in = (s1_adv && s1_produce_ff) ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_produce_ff) begin
         s2_sum_ff   <= new_sum;
         s2_marks_ff <= s1_marks_ff;
      end
   end

   // reciprocal multiply gives the exact truncated quotient
   bxavg_pkg::pixel_type avg_pix;
   logic [ProdW-1:0]     prod [bxavg_pkg::NumChan];

   always_comb begin
      avg_pix = '0;
      for (int k = 0; k < bxavg_pkg::NumChan; k++) begin
         prod[k] = ProdW'(s2_sum_ff[k*SumW +: SumW]) * ProdW'(Recip);
         avg_pix[k*bxavg_pkg::ChanW +: bxavg_pkg::ChanW] = prod[k][ShiftW +: bxavg_pkg::ChanW];
      end
   end

   // ---------------------------------------------------------------- output register
   assign rsp_valid_in = s2_adv ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rsp_pix_ff   <= avg_pix;
         rsp_marks_ff <= s2_marks_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pix_ff;
   assign rsp_tlast  = rsp_marks_ff.row_last;
   assign rsp_tuser  = rsp_marks_ff.frame_last;

   // ---------------------------------------------------------------- checks
   a_frame_end_ends_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tuser || rsp_tlast))
      else $error("frame end without row end");

   a_taken_word_in_stage1: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("taken word missing from stage 1");

   a_write_needs_word: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (s1_valid_ff && s1_write_ff))
      else $error("line memory written without a word");

   a_row_start_clean: assert property (@(posedge clock) disable iff (reset)
      (col_ff == '0) |-> (col_phase_ff == '0 && blk_ff == '0 && blk_start_ff == '0))
      else $error("column counters out of step");

   a_stall_holds_s2: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !out_free) |=> (s2_valid_ff && $stable(s2_sum_ff)))
      else $error("stage 2 lost its sums under back pressure");

endmodule

`default_nettype wire

// File: dv/box_average_downscale_by_four_core_check.sv
module box_average_downscale_by_four_core_check (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // source pixel channel
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   input  wire logic [23:0]                    req_tdata,   // red_in, green_in, blue_in
   // averaged pixel channel
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic [23:0]                    rsp_tdata,   // red_out, green_out, blue_out
   input  wire logic                           rsp_tlast,   // row_end
   input  wire logic                           rsp_tuser,   // frame_end
   // register port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [bxavg_pkg::CsrAddrW-1:0] csr_paddr,
   input  wire logic [bxavg_pkg::CsrDataW-1:0] csr_pwdata,
   input  wire logic [bxavg_pkg::CsrDataW-1:0] csr_prdata,
   input  wire logic                           csr_pready,
   // status for the stimulus side
   output int unsigned                         averages_owed,
   output int unsigned                         mismatch_total
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Scale       = 4;
   localparam int MaxWidth    = 2048;
   localparam int NumBlocks   = MaxWidth / Scale;
   localparam int Area        = Scale * Scale;
   localparam int SumW        = bxavg_pkg::ChanW + $clog2(Area);
   localparam int ColW        = $clog2(MaxWidth);
   localparam int ResetWidth  = 640;
   localparam int ResetHeight = 480;
   localparam int ReportLimit = 10;

   // one averaged output pixel with its markers
   typedef struct packed {
      logic                 row_end;
      logic                 frame_end;
      bxavg_pkg::pixel_type px;
   } averaged_type;

   // shadow of the registers and of the frame position
   logic [bxavg_pkg::CfgW-1:0] width_reg;
   logic [bxavg_pkg::CfgW-1:0] height_reg;
   logic [ColW-1:0]            column;
   logic [bxavg_pkg::CfgW-1:0] row;

   // partial channel sums, one entry per block column
   logic [SumW-1:0] block_sum [NumBlocks][bxavg_pkg::NumChan];

   averaged_type owed_q[$];
   int unsigned  errors = 0;

   function automatic void flag_failure(input string what);
      errors++;
      if (errors <= ReportLimit) $display("%0t: %s", $time, what);
   endfunction

   // fold one source pixel into its block, queue the average when the block closes
   function automatic void accumulate_pixel(input bxavg_pkg::pixel_type pix);
      int unsigned  eff_width;
      int unsigned  blocks_wide;
      int unsigned  blocks_high;
      int unsigned  bx;
      int unsigned  by;
      int           k;
      logic         opens;
      logic         closes;
      averaged_type avg;
      eff_width   = (width_reg > MaxWidth) ? MaxWidth : width_reg;
      blocks_wide = eff_width / Scale;
      blocks_high = height_reg / Scale;
      bx          = column / Scale;
      by          = row / Scale;
      if (bx < blocks_wide && by < blocks_high) begin
         opens  = (row % Scale == 0) && (column % Scale == 0);
         closes = (row % Scale == Scale - 1) && (column % Scale == Scale - 1);
         for (k = 0; k < bxavg_pkg::NumChan; k++) begin
            if (opens) begin
               block_sum[bx][k] = SumW'(pix[k*bxavg_pkg::ChanW +: bxavg_pkg::ChanW]);
            end else begin
               block_sum[bx][k] = block_sum[bx][k] +
                  SumW'(pix[k*bxavg_pkg::ChanW +: bxavg_pkg::ChanW]);
            end
         end
         if (closes) begin
            for (k = 0; k < bxavg_pkg::NumChan; k++) begin
               avg.px[k*bxavg_pkg::ChanW +: bxavg_pkg::ChanW] =
                  bxavg_pkg::ChanW'(block_sum[bx][k] / Area);
            end
            avg.row_end   = (bx + 1 == blocks_wide);
            avg.frame_end = avg.row_end && (by + 1 == blocks_high);
            owed_q.push_back(avg);
         end
      end
      // advance the raster position
      if (column + 1 >= eff_width) begin
         column = '0;
         row    = (row + 1 >= height_reg) ? '0 : row + 1'b1;
      end else begin
         column = column + 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      averaged_type                   want;
      logic [bxavg_pkg::CsrDataW-1:0] reg_value;
      if (reset) begin
         width_reg  = bxavg_pkg::CfgW'(ResetWidth);
         height_reg = bxavg_pkg::CfgW'(ResetHeight);
         column     = '0;
         row        = '0;
         owed_q.delete();
      end else begin
         // register writes and read-back
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == bxavg_pkg::REG_SOURCE_WIDTH) begin
                  width_reg = csr_pwdata[bxavg_pkg::CfgW-1:0];
               end else begin
                  height_reg = csr_pwdata[bxavg_pkg::CfgW-1:0];
               end
            end else begin
               reg_value = '0;
               reg_value[bxavg_pkg::CfgW-1:0] =
                  (csr_paddr[2] == bxavg_pkg::REG_SOURCE_WIDTH) ? width_reg : height_reg;
               if (csr_prdata !== reg_value) begin
                  flag_failure($sformatf("register read at %0d: expected %0d, got %0d",
                                         csr_paddr, reg_value, csr_prdata));
               end
            end
         end
         // source word taken
         if (req_tvalid && req_tready) accumulate_pixel(req_tdata);
         // averaged word taken
         if (rsp_tvalid && rsp_tready) begin
            if (owed_q.size() == 0) begin
               flag_failure($sformatf("averaged word with none owed: rgb %0d/%0d/%0d %0b%0b",
                                      rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16],
                                      rsp_tlast, rsp_tuser));
            end else begin
               want = owed_q.pop_front();
               if (rsp_tdata !== want.px || rsp_tlast !== want.row_end ||
                   rsp_tuser !== want.frame_end) begin
                  flag_failure($sformatf({"averaged word: expected rgb %0d/%0d/%0d row_end %0b ",
                                          "frame_end %0b, got rgb %0d/%0d/%0d row_end %0b ",
                                          "frame_end %0b"},
                                         want.px.red, want.px.green, want.px.blue,
                                         want.row_end, want.frame_end,
                                         rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16],
                                         rsp_tlast, rsp_tuser));
               end
            end
         end
      end
      averages_owed  <= owed_q.size();
      mismatch_total <= errors;
   end

endmodule

// File: dv/box_average_downscale_by_four_core_test.sv
module box_average_downscale_by_four_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int      MaxWidth     = 2048;
   localparam int      RandomItems  = 1200;
   localparam int      HoldCycles   = 400;
   localparam int      SettleCycles = 8;
   localparam longint  TimeoutNs    = 30_000_000;

   typedef enum int unsigned {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_RARELY,
      READY_EVERY_THIRD
   } stall_pattern_type;

   logic                           clock;
   logic                           reset       = 1'b1;
   logic                           req_tvalid  = 1'b0;
   logic                           req_tready;
   logic [23:0]                    req_tdata   = '0;   // red_in, green_in, blue_in
   logic                           rsp_tvalid;
   logic                           rsp_tready  = 1'b0;
   logic [23:0]                    rsp_tdata;          // red_out, green_out, blue_out
   logic                           rsp_tlast;          // row_end
   logic                           rsp_tuser;          // frame_end
   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [bxavg_pkg::CsrAddrW-1:0] csr_paddr   = '0;
   logic [bxavg_pkg::CsrDataW-1:0] csr_pwdata  = '0;
   logic [bxavg_pkg::CsrDataW-1:0] csr_prdata;
   logic                           csr_pready;

   int unsigned                    averages_owed;
   int unsigned                    mismatch_total;

   // stimulus bookkeeping
   int unsigned                    burst_left  = 0;
   int unsigned                    pixels_sent = 0;
   logic [bxavg_pkg::CfgW-1:0]     width_now   = 12'd640;
   logic [bxavg_pkg::CfgW-1:0]     height_now  = 12'd480;
   bit                             squeeze_request = 1'b0;

   box_average_downscale_by_four_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   box_average_downscale_by_four_core_check averager_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .averages_owed  (averages_owed),
      .mismatch_total (mismatch_total)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // channels often pinned at the rails
   function automatic bxavg_pkg::pixel_type random_pixel();
      bxavg_pkg::pixel_type pix;
      int                   k;
      for (k = 0; k < bxavg_pkg::NumChan; k++) begin
         case ($urandom_range(0, 9))
            0:       pix[k*bxavg_pkg::ChanW +: bxavg_pkg::ChanW] = '0;
            1:       pix[k*bxavg_pkg::ChanW +: bxavg_pkg::ChanW] = '1;
            default: pix[k*bxavg_pkg::ChanW +: bxavg_pkg::ChanW] =
                        bxavg_pkg::ChanW'($urandom_range(0, 255));
         endcase
      end
      return pix;
   endfunction

   // register value, mostly a few blocks, sometimes under one block or larger
   function automatic logic [bxavg_pkg::CfgW-1:0] pick_size(input int unsigned typical_max);
      case ($urandom_range(0, 9))
         0:       return bxavg_pkg::CfgW'($urandom_range(0, 3));
         1:       return bxavg_pkg::CfgW'($urandom_range(typical_max + 1, typical_max * 3));
         default: return bxavg_pkg::CfgW'($urandom_range(4, typical_max));
      endcase
   endfunction

   // zero behaves as one, width saturates at the line store
   function automatic int unsigned pixels_per_row();
      if (width_now == 0) return 1;
      return (width_now > MaxWidth) ? MaxWidth : width_now;
   endfunction

   function automatic int unsigned rows_per_frame();
      return (height_now == 0) ? 1 : height_now;
   endfunction

   // one source word, in bursts with random gaps
   task automatic send_pixel(input bxavg_pkg::pixel_type pix);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                  : $urandom_range(1, 30);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      pixels_sent++;
   endtask

   task automatic send_run(input int unsigned count);
      repeat (count) send_pixel(random_pixel());
   endtask

   // drain every owed word and let the pipeline settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (averages_owed != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // one register transfer, setup then access
   task automatic csr_access(input logic write, input logic which,
                             input logic [bxavg_pkg::CfgW-1:0] value);
      logic [bxavg_pkg::CsrDataW-1:0] word;
      word                      = $urandom();
      word[bxavg_pkg::CfgW-1:0] = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (write) begin
         if (which == bxavg_pkg::REG_SOURCE_WIDTH) width_now = value;
         else height_now = value;
      end
   endtask

   // new frame size while idle, occasional rewrite of an unchanged value and read-back
   task automatic set_frame_size(input logic [bxavg_pkg::CfgW-1:0] w,
                                 input logic [bxavg_pkg::CfgW-1:0] h);
      wait_idle();
      if (w != width_now || $urandom_range(0, 3) == 0) begin
         csr_access(1'b1, bxavg_pkg::REG_SOURCE_WIDTH, w);
      end
      if (h != height_now || $urandom_range(0, 3) == 0) begin
         csr_access(1'b1, bxavg_pkg::REG_SOURCE_HEIGHT, h);
      end
      if ($urandom_range(0, 3) == 0) begin
         csr_access(1'b0, bxavg_pkg::REG_SOURCE_WIDTH, '0);
         csr_access(1'b0, bxavg_pkg::REG_SOURCE_HEIGHT, '0);
      end
   endtask

   // receiver: stretches of different stall patterns, one long hold-off on request
   initial begin
      int unsigned       stretch;
      int unsigned       beat;
      bit                squeeze_done;
      stall_pattern_type pattern;
      stretch      = 0;
      beat         = 0;
      squeeze_done = 1'b0;
      pattern      = READY_ALWAYS;
      forever begin
         @(posedge clock);
         if (squeeze_request && !squeeze_done) begin
            squeeze_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
         end else begin
            if (stretch == 0) begin
               stretch = $urandom_range(5, 150);
               pattern = stall_pattern_type'($urandom_range(0, 3));
            end
            stretch--;
            beat++;
            case (pattern)
               READY_ALWAYS:  rsp_tready <= 1'b1;
               READY_MOSTLY:  rsp_tready <= ($urandom_range(0, 3) != 0);
               READY_RARELY:  rsp_tready <= ($urandom_range(0, 3) == 0);
               default:       rsp_tready <= (beat % 3 == 0);
            endcase
         end
      end
   end

   // stimulus and verdict
   initial begin
      int unsigned random_start;
      int unsigned rows_left;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers come out of reset at their defaults
      csr_access(1'b0, bxavg_pkg::REG_SOURCE_WIDTH, '0);
      csr_access(1'b0, bxavg_pkg::REG_SOURCE_HEIGHT, '0);

      // one block, every channel at full scale
      set_frame_size(12'd4, 12'd4);
      repeat (16) send_pixel('1);
      // zero width and height: each pixel closes a row and a frame
      set_frame_size(12'd0, 12'd0);
      repeat (3) send_pixel('0);
      // frame smaller than one block in both directions
      set_frame_size(12'd3, 12'd2);
      send_run(6);

      // tall narrow frame, receiver backs the block up
      set_frame_size(12'd4, 12'd64);
      squeeze_request = 1'b1;
      send_run(pixels_per_row() * rows_per_frame());

      // random frames, some resized after the first block row
      random_start = pixels_sent;
      while (pixels_sent - random_start < RandomItems) begin
         set_frame_size(pick_size(24), pick_size(12));
         if (rows_per_frame() >= 5 && $urandom_range(0, 4) == 0) begin
            send_run(4 * pixels_per_row());
            set_frame_size(pick_size(24), pick_size(12));
            rows_left = (rows_per_frame() > 5) ? rows_per_frame() - 4 : 1;
            send_run(rows_left * pixels_per_row());
         end else begin
            send_run(pixels_per_row() * rows_per_frame());
         end
      end

      wait_idle();
      if (mismatch_total == 0) begin
         $display("box_average_downscale_by_four_core test passed");
      end else begin
         $display("box_average_downscale_by_four_core test failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #(TimeoutNs);
      $display("box_average_downscale_by_four_core test failed");
      $finish;
   end

endmodule

// File: sim.f
sv/bxavg_pkg.sv
sv/bxavg_ram.sv
sv/box_average_downscale_by_four_core.sv
dv/box_average_downscale_by_four_core_check.sv
dv/box_average_downscale_by_four_core_test.sv
